// ----- sv/rmcs_pkg.sv -----
// ---------------------------------------------------------------------------
// Radiation-material coupling step package
// Shared types, widths and constants for the controller and the datapath.
// ---------------------------------------------------------------------------
package rmcs_pkg;

    localparam int unsigned FieldW  = 31;
    localparam int unsigned SumW    = 48;
    localparam int unsigned MagW    = 46;
    localparam int unsigned NumW    = 80;
    localparam int unsigned DivSteps = 80;
    localparam int unsigned DivEarly = 40;
    localparam int unsigned CntW    = 7;
    localparam int unsigned QuotW   = 40;

    localparam logic CfgRadConst = 1'b0;
    localparam logic CfgTimeStep = 1'b1;

    typedef enum logic [3:0] {
        ST_NONE,
        ST_TT,
        ST_T2,
        ST_AK,
        ST_KT,
        ST_AD,
        ST_ACC,
        ST_LO,
        ST_HI,
        ST_DIV,
        ST_FIN
    } t_step;

    typedef struct packed {
        logic  capture;
        t_step step;
        logic  div_early;
        logic  load_out;
    } t_cmd;

    typedef struct packed {
        logic func;
        logic last;
    } t_status;

endpackage

// ----- sv/radiation_material_coupling_step.sv -----
// ---------------------------------------------------------------------------
// Radiation-material coupling step
// Per-group emissive source and heating update in Q16.16 fixed point.
// ---------------------------------------------------------------------------
// Input items arrive on the slave stream; tuser is the mode (0 emissive,
// 1 heating) and tlast marks the last group of a cell.
// Emissive items form their result from four chained products through the
// single shared multiplier.
// Heating items that are not the last group give no result.
// The last heating group presents its result after the 80-step restoring
// divider, which divides the accumulated energy, times the time step, by
// the cell's thermal mass.
// One item is in flight at a time; tready is high only when idle.
// Results wait in an output register; a stalled receiver holds the block
// when the next result is ready, and no new item is accepted meanwhile.
// Reset clears the energy accumulator, sets the time step to 1.0 and the
// radiation constant to zero. Configuration writes are always accepted.
// ---------------------------------------------------------------------------
module radiation_material_coupling_step (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // cell_temperature, absorption, group_flux, group_source, cell_heat_cap
    input  logic [159:0] i_s_tdata,
    // func
    input  logic         i_s_tuser,
    input  logic         i_s_tlast,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // value
    output logic [31:0]  o_m_tdata,
    // saturated
    output logic         o_m_tuser,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_index,
    input  logic [30:0]  i_cfg_data
);

    rmcs_pkg::t_cmd    cmd;
    rmcs_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    rmcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    rmcs_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_tdata     (i_s_tdata),
        .i_func      (i_s_tuser),
        .i_last      (i_s_tlast),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_value     (o_m_tdata),
        .o_saturated (o_m_tuser)
    );

endmodule

// ----- sv/rmcs_dp.sv -----
// ---------------------------------------------------------------------------
// Radiation-material coupling datapath
// One shared multiplier, the energy accumulator and a bit-serial divider.
// ---------------------------------------------------------------------------
module rmcs_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rmcs_pkg::t_cmd        i_cmd,
    output rmcs_pkg::t_status     o_status,
    input  logic [159:0]          i_tdata,
    input  logic                  i_func,
    input  logic                  i_last,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [30:0]           i_cfg_data,
    output logic [31:0]           o_value,
    output logic                  o_saturated
);

    logic        r_func, r_last;
    logic [30:0] r_temp, r_absn, r_flux, r_src, r_cap;
    logic [30:0] r_rad, r_ts;
    logic [30:0] r_t2, r_t4, r_ks;
    logic [45:0] r_mag;
    logic        r_neg;
    logic [47:0] r_sum;
    logic        r_sum_clip;
    logic        r_sat;
    logic [62:0] r_p0;
    logic [79:0] r_num;
    logic [31:0] r_rem;
    logic [39:0] r_q;
    logic        r_big, r_azero;
    logic [31:0] r_res;
    logic        r_res_sat;

    logic [31:0] op_a, op_b;
    logic [63:0] prod;
    logic [47:0] prod_sh;
    logic        prod_ovf;
    logic [30:0] prod_sat;
    logic [47:0] abs_sum;
    logic [48:0] term, acc;
    logic [32:0] rr;
    logic        div_bit;
    logic [34:0] qv;
    logic [35:0] fin_v;

    always_comb begin
        abs_sum = r_sum[47] ? 48'(-r_sum) : r_sum;
        op_a = '0;
        op_b = '0;
        case (i_cmd.step)
            rmcs_pkg::ST_TT: begin op_a = {1'b0, r_temp}; op_b = {1'b0, r_temp}; end
            rmcs_pkg::ST_T2: begin op_a = {1'b0, r_t2};   op_b = {1'b0, r_t2};   end
            rmcs_pkg::ST_AK: begin op_a = {1'b0, r_absn}; op_b = {1'b0, r_rad};  end
            rmcs_pkg::ST_KT: begin op_a = {1'b0, r_ks};   op_b = {1'b0, r_t4};   end
            rmcs_pkg::ST_AD: begin
                op_a = {1'b0, r_absn};
                op_b = (r_flux < r_src) ? {1'b0, r_src - r_flux} : {1'b0, r_flux - r_src};
            end
            rmcs_pkg::ST_LO: begin op_a = abs_sum[31:0]; op_b = {1'b0, r_ts}; end
            rmcs_pkg::ST_HI: begin op_a = {16'b0, abs_sum[47:32]}; op_b = {1'b0, r_ts}; end
            default: begin op_a = '0; op_b = '0; end
        endcase
        prod     = op_a * op_b;
        prod_sh  = prod[63:16];
        prod_ovf = |prod_sh[47:31];
        prod_sat = prod_ovf ? 31'h7FFF_FFFF : prod_sh[30:0];

        term = r_neg ? 49'(-{3'b0, r_mag}) : {3'b0, r_mag};
        acc  = {r_sum[47], r_sum} + term;

        rr      = {r_rem, r_num[79]};
        div_bit = (rr >= {2'b0, r_cap});

        if (r_azero) begin
            qv = '0;
        end else if (r_big || ({1'b0, r_q} > 41'h2_0000_0000)) begin
            qv = 35'h2_0000_0000;
        end else begin
            qv = r_q[34:0];
        end
        fin_v = r_sum[47] ? ({5'b0, r_temp} - {1'b0, qv}) : ({5'b0, r_temp} + {1'b0, qv});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rad      <= '0;
            r_ts       <= 31'd65536;
            r_sum      <= '0;
            r_sum_clip <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == rmcs_pkg::CfgRadConst) begin
                    r_rad <= i_cfg_data;
                end else begin
                    r_ts <= i_cfg_data;
                end
            end
            if (i_cmd.step == rmcs_pkg::ST_ACC) begin
                if (acc[48] != acc[47]) begin
                    r_sum      <= acc[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
                    r_sum_clip <= 1'b1;
                end else begin
                    r_sum <= acc[47:0];
                end
            end else if (i_cmd.step == rmcs_pkg::ST_FIN) begin
                r_sum      <= '0;
                r_sum_clip <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func <= i_func;
            r_last <= i_last;
            r_temp <= i_tdata[30:0];
            r_absn <= i_tdata[61:31];
            r_flux <= i_tdata[92:62];
            r_src  <= i_tdata[123:93];
            r_cap  <= i_tdata[154:124];
        end
        case (i_cmd.step)
            rmcs_pkg::ST_TT: begin r_t2 <= prod_sat; r_sat <= prod_ovf; end
            rmcs_pkg::ST_T2: begin r_t4 <= prod_sat; r_sat <= r_sat | prod_ovf; end
            rmcs_pkg::ST_AK: begin r_ks <= prod_sat; r_sat <= r_sat | prod_ovf; end
            rmcs_pkg::ST_KT: begin
                r_res     <= {1'b0, prod_sat};
                r_res_sat <= r_sat | prod_ovf;
            end
            rmcs_pkg::ST_AD: begin
                r_mag <= prod[61:16];
                r_neg <= (r_flux < r_src);
            end
            rmcs_pkg::ST_LO: r_p0 <= prod[62:0];
            rmcs_pkg::ST_HI: begin
                r_num   <= 80'(r_p0) + (80'(prod[46:0]) << 32);
                r_rem   <= '0;
                r_q     <= '0;
                r_big   <= 1'b0;
                r_azero <= (abs_sum == '0);
            end
            rmcs_pkg::ST_DIV: begin
                r_rem <= div_bit ? 32'(rr - {2'b0, r_cap}) : rr[31:0];
                r_num <= {r_num[78:0], 1'b0};
                if (i_cmd.div_early) begin
                    r_big <= r_big | div_bit;
                end else begin
                    r_q <= {r_q[38:0], div_bit};
                end
            end
            rmcs_pkg::ST_FIN: begin
                if ($signed(fin_v) > 36'sh0_7FFF_FFFF) begin
                    r_res     <= 32'h7FFF_FFFF;
                    r_res_sat <= 1'b1;
                end else if ($signed(fin_v) < -36'sh0_8000_0000) begin
                    r_res     <= 32'h8000_0000;
                    r_res_sat <= 1'b1;
                end else begin
                    r_res     <= fin_v[31:0];
                    r_res_sat <= r_sum_clip;
                end
            end
            default: begin end
        endcase
        if (i_cmd.load_out) begin
            o_value     <= r_res;
            o_saturated <= r_res_sat;
        end
    end

    assign o_status.func = r_func;
    assign o_status.last = r_last;

endmodule

// ----- sv/rmcs_ctrl.sv -----
// ---------------------------------------------------------------------------
// Radiation-material coupling controller
// Sequences the multiplier, divider and output register for each item.
// ---------------------------------------------------------------------------
module rmcs_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    input  rmcs_pkg::t_status  i_status,
    output rmcs_pkg::t_cmd     o_cmd
);

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_ONE  = 11'b000_0000_0010,
        S_E2   = 11'b000_0000_0100,
        S_E3   = 11'b000_0000_1000,
        S_E4   = 11'b000_0001_0000,
        S_ACC  = 11'b000_0010_0000,
        S_LO   = 11'b000_0100_0000,
        S_HI   = 11'b000_1000_0000,
        S_DIV  = 11'b001_0000_0000,
        S_FIN  = 11'b010_0000_0000,
        S_EMIT = 11'b100_0000_0000
    } t_state;

    t_state         r_state, n_state;
    logic [6:0]     r_cnt, n_cnt;
    logic           r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid & ~i_m_tready;
        o_cmd       = '{capture: 1'b0, step: rmcs_pkg::ST_NONE,
                        div_early: 1'b0, load_out: 1'b0};
        o_cmd.div_early = (r_cnt < 7'(rmcs_pkg::DivEarly));
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_ONE;
                end
            end
            S_ONE: begin
                o_cmd.step = i_status.func ? rmcs_pkg::ST_AD : rmcs_pkg::ST_TT;
                n_state = i_status.func ? S_ACC : S_E2;
            end
            S_E2: begin o_cmd.step = rmcs_pkg::ST_T2; n_state = S_E3; end
            S_E3: begin o_cmd.step = rmcs_pkg::ST_AK; n_state = S_E4; end
            S_E4: begin o_cmd.step = rmcs_pkg::ST_KT; n_state = S_EMIT; end
            S_ACC: begin
                o_cmd.step = rmcs_pkg::ST_ACC;
                n_state = i_status.last ? S_LO : S_IDLE;
            end
            S_LO: begin o_cmd.step = rmcs_pkg::ST_LO; n_state = S_HI; end
            S_HI: begin
                o_cmd.step = rmcs_pkg::ST_HI;
                n_cnt = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.step = rmcs_pkg::ST_DIV;
                n_cnt = r_cnt + 7'd1;
                if (r_cnt == 7'(rmcs_pkg::DivSteps - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin o_cmd.step = rmcs_pkg::ST_FIN; n_state = S_EMIT; end
            S_EMIT: begin
                if (!r_out_valid || i_m_tready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state == S_ONE))
        else $error("Accepted item did not start processing.");
    a_div_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_cnt == 7'(rmcs_pkg::DivSteps - 1)) |=> (r_state == S_FIN))
        else $error("Divider did not finish after its last step.");
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |=> r_out_valid)
        else $error("Loaded result not presented.");
`endif

endmodule
